[rtl/core/mjie_pkg.sv]
// Shared types, codes, constants and helpers of the joint encoder estimator.
`default_nettype none

package mjie_pkg;

  // Number of joints with filter state by default.
  localparam int unsigned JointTypesDefault = 32;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ANGLE_SCALE   = 3'd0,
    CFG_SAMPLE_RATE   = 3'd1,
    CFG_FLIP_DEFAULT  = 3'd2,
    CFG_FLIP_SQUARE   = 3'd3,
    CFG_FLIP_DV       = 3'd4
  } cfg_idx_e;

  localparam logic [15:0] SampleRateReset = 16'd1000;

  // Item commands and adapter styles.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_RESET  = 1'b1;

  localparam logic [1:0] STYLE_DEFAULT = 2'd0;
  localparam logic [1:0] STYLE_SQUARE  = 2'd1;
  localparam logic [1:0] STYLE_DV      = 2'd2;

  // Filter coefficients, Q2.16. The feedforward taps are symmetric.
  localparam int unsigned CoefW = 18;
  localparam logic signed [CoefW-1:0] COEF_B_OUTER = 18'sd1877;
  localparam logic signed [CoefW-1:0] COEF_B_INNER = 18'sd5630;
  localparam logic signed [CoefW-1:0] COEF_A1      = 18'sd99543;
  localparam logic signed [CoefW-1:0] COEF_A2      = -18'sd62915;
  localparam logic signed [CoefW-1:0] COEF_A3      = 18'sd13894;

  // Multiply-accumulate widths.
  localparam int unsigned MacAW  = 34;
  localparam int unsigned ProdW  = MacAW + CoefW;
  localparam int unsigned AccW   = 54;
  localparam int unsigned QShift = 16;

  typedef struct packed {
    logic               command;
    logic [4:0]         joint_type;
    logic [1:0]         mount_style;
    logic signed [31:0] encoder_count;
    logic signed [31:0] encoder_offset;
    logic signed [31:0] reset_position;
  } in_item_t;

  typedef struct packed {
    logic [4:0]         joint_echo;
    logic signed [31:0] position;
    logic signed [31:0] velocity;
  } out_item_t;

  // One memory word holds the whole history of a joint.
  typedef struct packed {
    logic signed [31:0] x0;
    logic signed [31:0] x1;
    logic signed [31:0] x2;
    logic signed [31:0] y0;
    logic signed [31:0] y1;
    logic signed [31:0] y2;
  } hist_t;

  typedef struct packed {
    logic en;
    logic first;
  } mac_req_t;

  // Saturates an accumulator value to signed 32 bits.
  function automatic logic signed [31:0] sat_acc(input logic signed [AccW-1:0] v);
    logic signed [31:0] r;
    if ((&v[AccW-1:31]) || (~|v[AccW-1:31])) begin
      r = v[31:0];
    end else if (v[AccW-1]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/mjie_hist_mem.sv]
// Per-joint filter history memory, one write and one registered read port.
`default_nettype none

module mjie_hist_mem #(
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = 5
) (
  input  wire logic             clk_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output mjie_pkg::hist_t       rd_data_o,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire mjie_pkg::hist_t  wr_data_i
);
  import mjie_pkg::*;

  hist_t mem_q [Depth];
  hist_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

[rtl/core/mjie_angle.sv]
// Two-stage pipeline from encoder count to a rounded, saturated Q16.16 angle.
`default_nettype none

module mjie_angle (
  input  wire logic               clk_i,
  input  wire logic signed [31:0] count_i,
  input  wire logic signed [31:0] offset_i,
  input  wire logic               flip_i,
  input  wire logic [31:0]        scale_i,
  output logic signed [31:0]      angle_o
);
  import mjie_pkg::*;

  logic signed [33:0] cnt;
  logic signed [33:0] diff;
  logic signed [33:0] mag_full;
  logic [63:0]        prod_q;
  logic               hi_q;
  logic               neg_q;
  logic [65:0]        total;
  logic [49:0]        quot;
  logic signed [31:0] angle_d;
  logic signed [31:0] angle_q;

  // The difference needs 34 bits; its magnitude fits 33, split into a
  // top bit and a 32-bit part for the multiplier.
  always_comb begin
    cnt      = flip_i ? -34'(count_i) : 34'(count_i);
    diff     = cnt - 34'(offset_i);
    mag_full = diff[33] ? -diff : diff;
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 64'(mag_full[31:0]) * 64'(scale_i);
    hi_q   <= mag_full[32];
    neg_q  <= diff[33];
  end

  always_comb begin
    total = {2'b00, prod_q} + (hi_q ? {2'b00, scale_i, 32'h0} : 66'h0)
          + 66'(1 << (QShift - 1));
    quot  = total[65:QShift];
    if (neg_q) begin
      angle_d = (quot > 50'h8000_0000) ? 32'sh8000_0000 : -quot[31:0];
    end else begin
      angle_d = (|quot[49:31]) ? 32'sh7fff_ffff : quot[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    angle_q <= angle_d;
  end

  assign angle_o = angle_q;

endmodule

`default_nettype wire

[rtl/core/mjie_mac.sv]
// Shared multiply-accumulate unit with a registered product.
`default_nettype none

module mjie_mac (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire mjie_pkg::mac_req_t                req_i,
  input  wire logic signed [mjie_pkg::MacAW-1:0] a_i,
  input  wire logic signed [mjie_pkg::CoefW-1:0] b_i,
  output logic signed [mjie_pkg::AccW-1:0]       acc_o
);
  import mjie_pkg::*;

  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q;
  mac_req_t                req_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q <= '0;
    end else begin
      req_q <= req_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= a_i * b_i;
    end
    if (req_q.en) begin
      acc_q <= req_q.first ? AccW'(prod_q) : acc_q + AccW'(prod_q);
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

[rtl/core/multi_joint_encoder_iir_estimator.sv]
// Top level of the multi-joint encoder position and velocity estimator.
//
// A sample request turns an encoder count into a Q16.16 angle and runs it
// through the joint's third-order low-pass filter; a reset request loads the
// joint's history with a given position. Requests are handled one at a time.
// For a sample request the sequencer passes ST_MUL and ST_RND for the angle
// multiplier and its rounding, ST_PREP to pick the joint's history, five
// passes through the one shared multiply-accumulate unit for the filter taps,
// ST_ACC and ST_FILT to drain and round the accumulator, ST_VEL, ST_VWAIT and
// ST_VSAT for the velocity product and its saturation, and ST_OUT to load the
// output register. A reset request, or a joint index not below JOINT_TYPES,
// goes from ST_MUL straight to ST_OUT. The next request is taken in ST_IDLE,
// after the previous one has reached the output register, even while that
// result still waits, so a request is not taken before the last one is
// through; a stalled output register holds the block in its last state. No
// clearing pass follows reset: a joint's first sample loads its history,
// tracked by one flag per joint.
`default_nettype none

module multi_joint_encoder_iir_estimator #(
  parameter int unsigned JOINT_TYPES = mjie_pkg::JointTypesDefault
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire mjie_pkg::in_item_t               in_item_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output mjie_pkg::out_item_t                   out_item_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [mjie_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [mjie_pkg::CfgDataW-1:0]    cfg_data_i
);
  import mjie_pkg::*;

  localparam int unsigned JW = (JOINT_TYPES > 1) ? $clog2(JOINT_TYPES) : 1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_RND,
    ST_PREP,
    ST_MAC,
    ST_ACC,
    ST_FILT,
    ST_VEL,
    ST_VWAIT,
    ST_VSAT,
    ST_OUT
  } state_e;

  state_e state_q, state_d;
  logic [2:0] step_q, step_d;
  logic out_valid_q, out_valid_d;
  out_item_t out_item_q, out_item_d;
  logic [JOINT_TYPES-1:0] joint_ready_q, joint_ready_d;

  logic [31:0] angle_scale_q;
  logic [15:0] sample_rate_q;
  logic [31:0] flip_default_q;
  logic [31:0] flip_square_q;
  logic [31:0] flip_dv_q;

  in_item_t           in_q;
  hist_t              hist_q;
  logic signed [32:0] s0_q;
  logic signed [32:0] s1_q;
  logic signed [31:0] filt_q;
  logic signed [31:0] res_pos_q;
  logic signed [31:0] res_vel_q;

  logic               accept;
  logic               joint_ok;
  logic [JW+4:0]      rd_ext;
  logic [JW+4:0]      wr_ext;
  logic [JW-1:0]      rd_addr;
  logic [JW-1:0]      wr_addr;
  logic               mem_rd_en;
  logic               mem_wr_en;
  hist_t              mem_rd_data;
  hist_t              mem_wr_data;
  hist_t              hist_sel;
  logic               first_sample;
  logic [31:0]        flip_mask;
  logic               flip;
  logic signed [31:0] angle;
  mac_req_t           mac_req;
  logic signed [MacAW-1:0] mac_a;
  logic signed [CoefW-1:0] mac_b;
  logic signed [AccW-1:0]  mac_acc;
  logic signed [AccW-1:0]  acc_rnd;
  logic signed [32:0]      vdiff;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_scale_q  <= '0;
      sample_rate_q  <= SampleRateReset;
      flip_default_q <= '0;
      flip_square_q  <= '0;
      flip_dv_q      <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_ANGLE_SCALE:  angle_scale_q  <= cfg_data_i;
        CFG_SAMPLE_RATE:  sample_rate_q  <= cfg_data_i[15:0];
        CFG_FLIP_DEFAULT: flip_default_q <= cfg_data_i;
        CFG_FLIP_SQUARE:  flip_square_q  <= cfg_data_i;
        CFG_FLIP_DV:      flip_dv_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Addressing and angle conversion
  // ---------------------------------------------------------------------
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  assign rd_ext  = (JW + 5)'(in_item_i.joint_type);
  assign wr_ext  = (JW + 5)'(in_q.joint_type);
  assign rd_addr = rd_ext[JW-1:0];
  assign wr_addr = wr_ext[JW-1:0];
  assign joint_ok = 32'(in_q.joint_type) < 32'(JOINT_TYPES);

  always_comb begin
    unique case (in_q.mount_style)
      STYLE_SQUARE: flip_mask = flip_square_q;
      STYLE_DV:     flip_mask = flip_dv_q;
      default:      flip_mask = flip_default_q;
    endcase
  end
  assign flip = flip_mask[in_q.joint_type];

  mjie_angle u_angle (
    .clk_i    (clk_i),
    .count_i  (in_q.encoder_count),
    .offset_i (in_q.encoder_offset),
    .flip_i   (flip),
    .scale_i  (angle_scale_q),
    .angle_o  (angle)
  );

  mjie_hist_mem #(
    .Depth (JOINT_TYPES),
    .AddrW (JW)
  ) u_hist_mem (
    .clk_i     (clk_i),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (mem_rd_data),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (mem_wr_data)
  );

  mjie_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mac_req),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .acc_o  (mac_acc)
  );

  // A joint without its flag set has never been sampled: its history is
  // taken as the new angle everywhere.
  assign first_sample = !joint_ready_q[wr_addr];

  always_comb begin
    if (first_sample) begin
      hist_sel = {6{angle}};
    end else begin
      hist_sel = mem_rd_data;
    end
  end

  assign acc_rnd = (mac_acc + AccW'(1 << (QShift - 1))) >>> QShift;
  assign vdiff   = 33'(filt_q) - 33'(hist_q.y0);

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_d       = state_q;
    step_d        = step_q;
    out_valid_d   = out_valid_q;
    out_item_d    = out_item_q;
    joint_ready_d = joint_ready_q;
    mem_rd_en     = 1'b0;
    mem_wr_en     = 1'b0;
    mem_wr_data   = {6{in_q.reset_position}};
    mac_req       = '0;
    mac_a         = 34'(s0_q);
    mac_b         = COEF_B_OUTER;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          mem_rd_en = 1'b1;
          state_d   = ST_MUL;
        end
      end
      ST_MUL: begin
        if (!joint_ok) begin
          state_d = ST_OUT;
        end else if (in_q.command == CMD_RESET) begin
          mem_wr_en = 1'b1;
          state_d   = ST_OUT;
        end else begin
          state_d = ST_RND;
        end
      end
      ST_RND: begin
        state_d = ST_PREP;
      end
      ST_PREP: begin
        joint_ready_d[wr_addr] = 1'b1;
        step_d  = '0;
        state_d = ST_MAC;
      end
      ST_MAC: begin
        mac_req.en    = 1'b1;
        mac_req.first = (step_q == 3'd0);
        case (step_q)
          3'd0: begin
            mac_a = 34'(s0_q);
            mac_b = COEF_B_OUTER;
          end
          3'd1: begin
            mac_a = 34'(s1_q);
            mac_b = COEF_B_INNER;
          end
          3'd2: begin
            mac_a = 34'(hist_q.y0);
            mac_b = COEF_A1;
          end
          3'd3: begin
            mac_a = 34'(hist_q.y1);
            mac_b = COEF_A2;
          end
          default: begin
            mac_a = 34'(hist_q.y2);
            mac_b = COEF_A3;
          end
        endcase
        step_d = step_q + 3'd1;
        if (step_q == 3'd4) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        state_d = ST_FILT;
      end
      ST_FILT: begin
        state_d = ST_VEL;
      end
      ST_VEL: begin
        mac_req.en    = 1'b1;
        mac_req.first = 1'b1;
        mac_a         = 34'(vdiff);
        mac_b         = signed'({2'b00, sample_rate_q});
        mem_wr_en     = 1'b1;
        mem_wr_data   = '{x0: angle, x1: hist_q.x0, x2: hist_q.x1,
                          y0: filt_q, y1: hist_q.y0, y2: hist_q.y1};
        state_d       = ST_VWAIT;
      end
      ST_VWAIT: begin
        state_d = ST_VSAT;
      end
      ST_VSAT: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d         = 1'b1;
          out_item_d.joint_echo = in_q.joint_type;
          out_item_d.position   = res_pos_q;
          out_item_d.velocity   = res_vel_q;
          state_d             = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      step_q        <= '0;
      out_valid_q   <= 1'b0;
      out_item_q    <= '0;
      joint_ready_q <= '0;
    end else begin
      state_q       <= state_d;
      step_q        <= step_d;
      out_valid_q   <= out_valid_d;
      out_item_q    <= out_item_d;
      joint_ready_q <= joint_ready_d;
    end
  end

  // Request payload and working values.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_item_i;
    end
    if (state_q == ST_MUL) begin
      res_vel_q <= '0;
      res_pos_q <= (joint_ok && in_q.command == CMD_RESET) ? in_q.reset_position : '0;
    end
    if (state_q == ST_PREP) begin
      hist_q <= hist_sel;
      s0_q   <= 33'(angle) + 33'(hist_sel.x2);
      s1_q   <= 33'(hist_sel.x0) + 33'(hist_sel.x1);
    end
    if (state_q == ST_FILT) begin
      filt_q <= sat_acc(acc_rnd);
    end
    if (state_q == ST_VSAT) begin
      res_pos_q <= filt_q;
      res_vel_q <= sat_acc(mac_acc);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

[dv/tb_multi_joint_encoder_iir_estimator.sv]
// Self-checking testbench for the multi-joint encoder low-pass estimator.
module tb_multi_joint_encoder_iir_estimator;
  import mjie_pkg::*;

  localparam int unsigned NumJoints = JointTypesDefault;
  localparam int unsigned Taps      = 3;
  localparam int unsigned RandomPerPhase = 230;
  localparam int unsigned DrainCycles    = 20;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_item_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_item_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  multi_joint_encoder_iir_estimator uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Register copies and filter state of the estimator.
  logic [31:0] scale_cfg = '0;
  longint      rate_cfg = 1000;
  logic [31:0] flip_cfg [3] = '{default: '0};
  longint      x_hist [NumJoints][Taps];
  longint      y_hist [NumJoints][Taps];
  bit          joint_seen [NumJoints] = '{default: 1'b0};

  in_item_t    pending_requests [$];
  out_item_t   expected_results [$];
  int          errors = 0;

  // Smooth per-joint encoder trajectories for well-formed sample streams.
  int          traj_pos [NumJoints];
  int          traj_off [NumJoints];

  int          in_gap = 0;
  int          out_gap = 0;
  bit          idling_on = 1'b1;
  bit          quiet = 1'b0;
  int unsigned cycle_count = 0;

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [31:0] flip_mask_for(input logic [1:0] style);
    case (style)
      STYLE_SQUARE: return flip_cfg[STYLE_SQUARE];
      STYLE_DV:     return flip_cfg[STYLE_DV];
      default:      return flip_cfg[STYLE_DEFAULT];
    endcase
  endfunction

  // Advances the joint's filter by one request and returns its result.
  function automatic out_item_t estimate(input in_item_t req);
    out_item_t   res;
    int          j;
    longint      cnt, diff, angle, acc, filt, vel;
    bit [63:0]   mag, q;
    logic [31:0] mask;
    j = int'(req.joint_type);
    res.joint_echo = req.joint_type;
    res.position   = '0;
    res.velocity   = '0;
    if (req.command == CMD_RESET) begin
      for (int k = 0; k < Taps; k++) begin
        x_hist[j][k] = longint'(req.reset_position);
        y_hist[j][k] = longint'(req.reset_position);
      end
      res.position = req.reset_position;
      return res;
    end
    cnt = longint'(req.encoder_count);
    mask = flip_mask_for(req.mount_style);
    if (mask[j]) cnt = -cnt;
    diff = cnt - longint'(req.encoder_offset);
    mag = (diff < 0) ? -diff : diff;
    q = (mag * scale_cfg + 64'd32768) >> 16;
    if (q > (64'd1 << 40)) q = 64'd1 << 40;
    angle = clip32((diff < 0) ? -longint'(q) : longint'(q));
    if (!joint_seen[j]) begin
      for (int k = 0; k < Taps; k++) begin
        x_hist[j][k] = angle;
        y_hist[j][k] = angle;
      end
      joint_seen[j] = 1'b1;
    end
    acc = 1877 * angle + 5630 * x_hist[j][0] + 5630 * x_hist[j][1] + 1877 * x_hist[j][2]
        + 99543 * y_hist[j][0] - 62915 * y_hist[j][1] + 13894 * y_hist[j][2];
    filt = clip32((acc + 32768) >>> 16);
    vel = clip32((filt - y_hist[j][0]) * rate_cfg);
    x_hist[j][2] = x_hist[j][1];
    x_hist[j][1] = x_hist[j][0];
    x_hist[j][0] = angle;
    y_hist[j][2] = y_hist[j][1];
    y_hist[j][1] = y_hist[j][0];
    y_hist[j][0] = filt;
    res.position = filt[31:0];
    res.velocity = vel[31:0];
    return res;
  endfunction

  function automatic in_item_t make_request(input logic cmd, input int j, input logic [1:0] style,
                                            input int cnt, input int off, input int rpos);
    in_item_t r;
    r.command        = cmd;
    r.joint_type     = j[4:0];
    r.mount_style    = style;
    r.encoder_count  = cnt;
    r.encoder_offset = off;
    r.reset_position = rpos;
    return r;
  endfunction

  // Mostly trajectory samples near the joint's offset; some resets and raw noise.
  function automatic in_item_t random_request();
    in_item_t    r;
    int          roll, j, tgt;
    logic [31:0] mask;
    r.command        = CMD_SAMPLE;
    r.joint_type     = 5'($urandom);
    r.mount_style    = 2'($urandom);
    r.encoder_count  = $urandom;
    r.encoder_offset = $urandom;
    r.reset_position = $urandom;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      r.command = CMD_RESET;
      if (roll < 5) r.reset_position = int'($urandom_range(0, 400000)) - 200000;
    end else if (roll >= 25) begin
      j = int'(r.joint_type);
      if ($urandom_range(0, 19) == 0) traj_pos[j] = int'($urandom_range(0, 80000)) - 40000;
      else traj_pos[j] += int'($urandom_range(0, 400)) - 200;
      tgt = traj_off[j] + traj_pos[j];
      mask = flip_mask_for(r.mount_style);
      r.encoder_count  = mask[j] ? -tgt : tgt;
      r.encoder_offset = traj_off[j];
    end
    return r;
  endfunction

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_ANGLE_SCALE:  scale_cfg = data;
      CFG_SAMPLE_RATE:  rate_cfg = longint'(data[15:0]);
      CFG_FLIP_DEFAULT: flip_cfg[STYLE_DEFAULT] = data;
      CFG_FLIP_SQUARE:  flip_cfg[STYLE_SQUARE] = data;
      CFG_FLIP_DV:      flip_cfg[STYLE_DV] = data;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [31:0] scale, input logic [31:0] rate,
                            input logic [31:0] f_def, input logic [31:0] f_sq,
                            input logic [31:0] f_dv);
    write_reg(CFG_ANGLE_SCALE, scale);
    write_reg(CFG_SAMPLE_RATE, rate);
    write_reg(CFG_FLIP_DEFAULT, f_def);
    write_reg(CFG_FLIP_SQUARE, f_sq);
    write_reg(CFG_FLIP_DV, f_dv);
  endtask

  task automatic add_random(input int n);
    for (int i = 0; i < n; i++) pending_requests.push_back(random_request());
  endtask

  // Waits until every request is sent and answered, then lets the pipeline drain.
  task automatic settle();
    while (pending_requests.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (quiet) idling_on <= 1'b0;
    else if (cycle_count % 64 == 0) idling_on <= ($urandom_range(0, 2) != 0);
  end

  always @(posedge clk_i) begin : drive_requests
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) expected_results.push_back(estimate(in_item_i));
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          in_item_i  <= pending_requests.pop_front();
          in_valid_i <= 1'b1;
          if (idling_on && $urandom_range(0, 3) == 0) in_gap = $urandom_range(1, 4);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, out_item_o);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_item_o.joint_echo !== want.joint_echo) begin
            $display("%0t: joint_echo expected %0d, actual %0d", $time,
                     want.joint_echo, out_item_o.joint_echo);
            errors++;
          end
          if (out_item_o.position !== want.position) begin
            $display("%0t: position (joint %0d) expected %0d, actual %0d", $time,
                     want.joint_echo, want.position, out_item_o.position);
            errors++;
          end
          if (out_item_o.velocity !== want.velocity) begin
            $display("%0t: velocity (joint %0d) expected %0d, actual %0d", $time,
                     want.joint_echo, want.velocity, out_item_o.velocity);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall_i <= 1'b1;
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
        out_gap = $urandom_range(0, 3);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : main_sequence
    for (int j = 0; j < NumJoints; j++) begin
      traj_off[j] = int'($urandom) >>> 1;
      traj_pos[j] = int'($urandom_range(0, 2000)) - 1000;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: first samples, resets, style fallback and count extremes.
    set_config(32'd6588397, 32'd1000, 32'h0000_0001, 32'h8000_0000, 32'hFFFF_FFFE);
    pending_requests.push_back(make_request(CMD_SAMPLE, 0, STYLE_DEFAULT, 1000, 0, 0));
    pending_requests.push_back(make_request(CMD_SAMPLE, 0, STYLE_DEFAULT, 1100, 0, 0));
    pending_requests.push_back(make_request(CMD_SAMPLE, 0, 2'd3, 1200, 0, 0));
    pending_requests.push_back(make_request(CMD_RESET, 0, STYLE_DEFAULT, 0, 0, 32'h7FFF_FFFF));
    pending_requests.push_back(make_request(CMD_SAMPLE, 0, STYLE_DEFAULT, 1300, 0, 0));
    pending_requests.push_back(make_request(CMD_RESET, 0, STYLE_DV, -1, -1, 32'h8000_0000));
    pending_requests.push_back(make_request(CMD_SAMPLE, 0, STYLE_SQUARE, 1400, 0, 0));
    // A reset before the first sample leaves the joint waiting for its first sample.
    pending_requests.push_back(make_request(CMD_RESET, 1, STYLE_SQUARE, 0, 0, 12345));
    pending_requests.push_back(make_request(CMD_SAMPLE, 1, STYLE_SQUARE, 50, 10, 0));
    pending_requests.push_back(make_request(CMD_SAMPLE, 1, STYLE_SQUARE, 60, 10, 0));
    pending_requests.push_back(make_request(CMD_SAMPLE, 31, STYLE_DEFAULT,
                                            32'h8000_0000, 32'h7FFF_FFFF, 0));
    pending_requests.push_back(make_request(CMD_SAMPLE, 31, STYLE_DEFAULT,
                                            32'h7FFF_FFFF, 32'h8000_0000, 0));
    pending_requests.push_back(make_request(CMD_SAMPLE, 31, STYLE_SQUARE,
                                            32'h7FFF_FFFF, 32'h8000_0000, 0));
    pending_requests.push_back(make_request(CMD_SAMPLE, 2, STYLE_DV,
                                            32'h8000_0000, 32'h7FFF_FFFF, 0));
    pending_requests.push_back(make_request(CMD_SAMPLE, 2, STYLE_DV,
                                            32'h8000_0000, 32'h8000_0000, 0));
    pending_requests.push_back(make_request(CMD_SAMPLE, 2, 2'd3, 0, 0, 0));
    pending_requests.push_back(make_request(CMD_SAMPLE, 3, STYLE_SQUARE, 0, 0, 0));
    pending_requests.push_back(make_request(CMD_SAMPLE, 3, STYLE_SQUARE, -1, 0, 0));
    pending_requests.push_back(make_request(CMD_SAMPLE, 3, STYLE_SQUARE, 1, 0, 0));
    pending_requests.push_back(make_request(CMD_RESET, 31, 2'd3, 0, 0, 0));
    pending_requests.push_back(make_request(CMD_SAMPLE, 31, STYLE_DV, 5, 5, 0));
    settle();

    set_config(32'hFFFF_FFFF, 32'd65535, 32'hFFFF_FFFF, 32'h0, $urandom);
    add_random(RandomPerPhase);
    settle();

    set_config(32'h0, 32'd1, $urandom, $urandom, $urandom);
    add_random(RandomPerPhase);
    settle();

    // Half-count scale makes rounding ties common; a zero rate forces zero velocity.
    set_config(32'h0000_8000, 32'd0, $urandom, $urandom, $urandom);
    add_random(RandomPerPhase);
    settle();

    set_config($urandom, $urandom_range(1, 65535), $urandom, $urandom, $urandom);
    add_random(RandomPerPhase);
    settle();

    quiet <= 1'b1;
    set_config(32'd6588397, 32'd1000, $urandom, $urandom, $urandom);
    add_random(RandomPerPhase);
    settle();

    if (errors == 0) begin
      $display("[multi_joint_encoder_iir_estimator] OK");
    end else begin
      $display("[multi_joint_encoder_iir_estimator] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #(8 * 500_000);
    $display("[multi_joint_encoder_iir_estimator] ERROR");
    $finish;
  end

endmodule
